// ===== src/esfd_pkg.sv =====
// shared types and constants for the escaped frame deframer
package esfd_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE = 8'h7D;
  localparam logic [7:0] ESC_KEEP = 8'h5D;
  localparam int POS_W = 14;
  localparam int ADDR_W = 14;
  localparam int COUNT_W = 14;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DELIMITER = 2'd1,
    ST_CHECKSUM  = 2'd2,
    ST_SHORT     = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          payload_byte;
    status_t             status;
    logic [ADDR_W-1:0]   link_address;
    logic [7:0]          protocol_version;
    logic [7:0]          operation_type;
    logic [7:0]          object_tag;
    logic [COUNT_W-1:0]  payload_count;
    logic                frame_done;
  } result_t;

endpackage

// ===== src/esfd_parser.sv =====
// frame state: delimiter check, unstuffing, checksum and header parse
module esfd_parser #(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_last,
  output logic                  res_valid,
  output esfd_pkg::result_t     res
);

  localparam int CAP_INT = (MAX_FRAME_BYTES - 1 > 16383) ? 16383 : MAX_FRAME_BYTES - 1;
  localparam logic [esfd_pkg::POS_W-1:0] POS_CAP = esfd_pkg::POS_W'(CAP_INT);

  typedef enum logic [2:0] {
    HDR_ADDR_LO   = 3'd0,
    HDR_ADDR_HI   = 3'd1,
    HDR_VERSION   = 3'd2,
    HDR_OPERATION = 3'd3,
    HDR_TAG       = 3'd4,
    HDR_PAYLOAD   = 3'd5
  } hdr_t;

  logic [esfd_pkg::POS_W-1:0]   byte_position, byte_position_next;
  logic                         head_ok, head_ok_next;
  logic                         escape_pending, escape_pending_next;
  logic [7:0]                   held_byte, held_byte_next;
  logic                         held_valid, held_valid_next;
  logic [7:0]                   xor_sum, xor_sum_next;
  hdr_t                         header_stage, header_stage_next;
  logic [esfd_pkg::ADDR_W-1:0]  address_reg, address_reg_next;
  logic [7:0]                   version_reg, version_reg_next;
  logic [7:0]                   operation_reg, operation_reg_next;
  logic [7:0]                   tag_reg, tag_reg_next;
  logic [esfd_pkg::COUNT_W-1:0] payload_counter, payload_counter_next;
  logic [7:0]                   decoded;
  logic                         have_decoded;
  esfd_pkg::status_t            sum_status;

  always_comb begin
    if (byte_position == '0) begin
      sum_status = (rx_byte == esfd_pkg::FLAG_BYTE) ? esfd_pkg::ST_SHORT
                                                     : esfd_pkg::ST_DELIMITER;
    end else if (!head_ok || rx_byte != esfd_pkg::FLAG_BYTE) begin
      sum_status = esfd_pkg::ST_DELIMITER;
    end else if (!held_valid || header_stage != HDR_PAYLOAD) begin
      sum_status = esfd_pkg::ST_SHORT;
    end else if (xor_sum != held_byte) begin
      sum_status = esfd_pkg::ST_CHECKSUM;
    end else begin
      sum_status = esfd_pkg::ST_OK;
    end
  end

  always_comb begin
    byte_position_next   = byte_position;
    head_ok_next         = head_ok;
    escape_pending_next  = escape_pending;
    held_byte_next       = held_byte;
    held_valid_next      = held_valid;
    xor_sum_next         = xor_sum;
    header_stage_next    = header_stage;
    address_reg_next     = address_reg;
    version_reg_next     = version_reg;
    operation_reg_next   = operation_reg;
    tag_reg_next         = tag_reg;
    payload_counter_next = payload_counter;
    decoded              = rx_byte;
    have_decoded         = 1'b0;
    res_valid            = 1'b0;
    res                  = '{kind: esfd_pkg::KIND_PAYLOAD, payload_byte: held_byte,
                             status: esfd_pkg::ST_OK, link_address: address_reg,
                             protocol_version: version_reg, operation_type: operation_reg,
                             object_tag: tag_reg, payload_count: payload_counter,
                             frame_done: 1'b0};

    if (frame_last) begin
      res_valid            = 1'b1;
      res.kind             = esfd_pkg::KIND_SUMMARY;
      res.payload_byte     = '0;
      res.status           = sum_status;
      res.frame_done       = 1'b1;
      byte_position_next   = '0;
      head_ok_next         = 1'b0;
      escape_pending_next  = 1'b0;
      held_byte_next       = '0;
      held_valid_next      = 1'b0;
      xor_sum_next         = '0;
      header_stage_next    = HDR_ADDR_LO;
      address_reg_next     = '0;
      version_reg_next     = '0;
      operation_reg_next   = '0;
      tag_reg_next         = '0;
      payload_counter_next = '0;
    end else if (byte_position == '0) begin
      head_ok_next       = (rx_byte == esfd_pkg::FLAG_BYTE);
      byte_position_next = esfd_pkg::POS_W'(1);
    end else if (head_ok && byte_position < POS_CAP) begin
      byte_position_next = byte_position + esfd_pkg::POS_W'(1);
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        decoded = (rx_byte == esfd_pkg::ESC_KEEP) ? esfd_pkg::ESC_BYTE : esfd_pkg::FLAG_BYTE;
        have_decoded = 1'b1;
      end else if (rx_byte == esfd_pkg::ESC_BYTE) begin
        escape_pending_next = 1'b1;
      end else begin
        have_decoded = 1'b1;
      end
    end

    // older held byte is not the checksum once a newer one decodes
    if (have_decoded) begin
      held_byte_next  = decoded;
      held_valid_next = 1'b1;
      if (held_valid) begin
        xor_sum_next = xor_sum ^ held_byte;
        unique case (header_stage)
          HDR_ADDR_LO: begin
            address_reg_next  = {8'd0, held_byte[7:2]};
            header_stage_next = held_byte[0] ? HDR_VERSION : HDR_ADDR_HI;
          end
          HDR_ADDR_HI: begin
            address_reg_next  = {held_byte[7:2], address_reg[7:0]};
            header_stage_next = HDR_VERSION;
          end
          HDR_VERSION: begin
            version_reg_next  = held_byte;
            header_stage_next = HDR_OPERATION;
          end
          HDR_OPERATION: begin
            operation_reg_next = held_byte;
            header_stage_next  = HDR_TAG;
          end
          HDR_TAG: begin
            tag_reg_next      = held_byte;
            header_stage_next = HDR_PAYLOAD;
          end
          default: begin
            if (payload_counter != esfd_pkg::COUNT_MAX) begin
              payload_counter_next = payload_counter + esfd_pkg::COUNT_W'(1);
            end
            res_valid         = 1'b1;
            res.payload_count = payload_counter_next;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      head_ok         <= 1'b0;
      escape_pending  <= 1'b0;
      held_byte       <= '0;
      held_valid      <= 1'b0;
      xor_sum         <= '0;
      header_stage    <= HDR_ADDR_LO;
      address_reg     <= '0;
      version_reg     <= '0;
      operation_reg   <= '0;
      tag_reg         <= '0;
      payload_counter <= '0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      head_ok         <= head_ok_next;
      escape_pending  <= escape_pending_next;
      held_byte       <= held_byte_next;
      held_valid      <= held_valid_next;
      xor_sum         <= xor_sum_next;
      header_stage    <= header_stage_next;
      address_reg     <= address_reg_next;
      version_reg     <= version_reg_next;
      operation_reg   <= operation_reg_next;
      tag_reg         <= tag_reg_next;
      payload_counter <= payload_counter_next;
    end
  end

endmodule

// ===== src/esfd_out_reg.sv =====
// result register with stream handshake toward the output
module esfd_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  esfd_pkg::result_t             res,
  output logic                          free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [esfd_pkg::DATA_W-1:0]   m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);

  esfd_pkg::result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
    if (free && load) begin
      held <= res;
    end
  end

  assign m_tdata = {2'b00, held.payload_count, held.object_tag, held.operation_type,
                    held.protocol_version, held.link_address, held.status,
                    held.payload_byte};
  assign m_tuser = held.kind;
  assign m_tlast = held.frame_done;

endmodule

// ===== src/escaped_frame_deframer_core.sv =====
// top level of the escaped frame deframer
// Takes one received byte per cycle unless the output stalls; the only
// storage is the frame state in the parser and a single result register, so
// a byte is accepted whenever the result register is empty or being drained.
// A frame runs from a 0x7E head to a 0x7E tail marked by s_tlast; body bytes
// are unstuffed, the last one is the XOR checksum, and the header (link
// address, version, operation type, object tag) is parsed ahead of the
// payload. Each payload byte appears one decoded byte late, and every tail
// yields a summary word (tuser high, tlast high) carrying the status.
module escaped_frame_deframer_core #(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic        s_tlast,   // frame_last
  output logic        m_tvalid,
  input  logic        m_tready,
  // payload_byte, status, link_address, protocol_version, operation_type,
  // object_tag, payload_count, zero fill
  output logic [63:0] m_tdata,
  output logic        m_tuser,   // kind
  output logic        m_tlast    // frame_done
);

  logic              accept;
  logic              res_valid;
  logic              free;
  esfd_pkg::result_t res;

  assign s_tready = free;
  assign accept   = s_tvalid && free;

  esfd_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (s_tdata),
    .frame_last (s_tlast),
    .res_valid  (res_valid),
    .res        (res)
  );

  esfd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && res_valid),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_tail_gives_summary: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid && m_tuser && m_tlast)
    else $error("tail word did not produce a summary");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> !m_tlast && m_tdata[9:8] == 2'd0)
    else $error("payload word carries summary fields");

  a_summary_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("summary word carries a payload byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
